@@ src/bse_pkg.sv @@
package bse_pkg;

  localparam int SymbolCount = 256;
  localparam int SymW        = 8;
  localparam int IdxW        = $clog2(SymbolCount);
  localparam int PosW        = IdxW + 1;
  localparam int GrpBits     = (IdxW < 4) ? IdxW : 4;
  localparam int GroupW      = 1 << GrpBits;
  localparam int GroupCount  = (SymbolCount + GroupW - 1) / GroupW;
  localparam int GidxW       = (IdxW > GrpBits) ? (IdxW - GrpBits) : 1;
  localparam int PadW        = GroupCount * GroupW;

  localparam logic [2:0] FuncClear   = 3'd0;
  localparam logic [2:0] FuncMark    = 3'd1;
  localparam logic [2:0] FuncPass    = 3'd2;
  localparam logic [2:0] FuncAbsent  = 3'd3;
  localparam logic [2:0] FuncPresent = 3'd4;
  localparam logic [2:0] FuncDrain   = 3'd5;

  typedef enum logic [1:0] {
    StIdle,
    StFind,
    StAhead
  } state_t;

  typedef struct packed {
    logic accept;
    logic advance;
    logic take;
    logic emit_hit;
    logic emit_found;
    logic found_last;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic fin;
  } status_t;

endpackage

@@ src/byte_set_engine.sv @@
// byte_set_engine: 256-entry byte membership set driven by one request at a time
// requests: every request but drain delivers its result (if any) in the cycle after
//   acceptance and keeps busy low, so those requests run at one per cycle while no drain is busy
// drain: the scan walks 16 positions per cycle from the cursor to the member, then,
//   unless final, on to the next member or the end of the set to decide last
// reset: rst (synchronous) empties the set, zeroes the cursor, drops strobe
module byte_set_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               func,
  input  logic [bse_pkg::SymW-1:0] symbol,
  input  logic                     final_req,
  output logic                     strobe,
  output logic [bse_pkg::SymW-1:0] out_symbol,
  output logic                     present,
  output logic                     last
);

  // command and status between the sequencer and the set datapath
  bse_pkg::cmd_t    cmd;
  bse_pkg::status_t status;

  // sequencer: idle takes every request, drain steps through find and look-ahead
  bse_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: membership flops, drain cursor, group scanner, result register
  bse_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .symbol     (symbol),
    .final_req  (final_req),
    .status     (status),
    .strobe     (strobe),
    .out_symbol (out_symbol),
    .present    (present),
    .last       (last)
  );

endmodule

@@ src/bse_ctrl.sv @@
module bse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       func,
  input  bse_pkg::status_t status,
  output bse_pkg::cmd_t    cmd,
  output logic             busy
);

  bse_pkg::state_t state;
  bse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bse_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bse_pkg::StIdle: begin
        if (start && func == bse_pkg::FuncDrain) begin
          state_next = bse_pkg::StFind;
        end
      end
      bse_pkg::StFind: begin
        if (status.hit) begin
          state_next = status.fin ? bse_pkg::StIdle : bse_pkg::StAhead;
        end else if (status.exhausted) begin
          state_next = bse_pkg::StIdle;
        end
      end
      bse_pkg::StAhead: begin
        if (status.hit || status.exhausted) begin
          state_next = bse_pkg::StIdle;
        end
      end
      default: state_next = bse_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      bse_pkg::StIdle: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      bse_pkg::StFind: begin
        if (status.hit) begin
          cmd.take     = 1'b1;
          cmd.emit_hit = status.fin;
        end else if (status.exhausted) begin
          cmd.emit_end = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      bse_pkg::StAhead: begin
        if (status.hit || status.exhausted) begin
          cmd.emit_found = 1'b1;
          cmd.found_last = !status.hit;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ src/bse_datapath.sv @@
module bse_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  bse_pkg::cmd_t             cmd,
  input  logic [2:0]                func,
  input  logic [bse_pkg::SymW-1:0]  symbol,
  input  logic                      final_req,
  output bse_pkg::status_t          status,
  output logic                      strobe,
  output logic [bse_pkg::SymW-1:0]  out_symbol,
  output logic                      present,
  output logic                      last
);

  logic [bse_pkg::SymbolCount-1:0] member_map;
  logic [bse_pkg::PosW-1:0]        drain_cursor;
  logic [bse_pkg::PosW-1:0]        pos;
  logic [bse_pkg::IdxW-1:0]        found;
  logic                            fin_q;

  logic                            in_range;
  logic                            member;
  logic                            emit;
  logic [bse_pkg::PadW-1:0]        map_pad;
  logic [bse_pkg::GidxW-1:0]       gidx;
  logic [bse_pkg::GroupW-1:0]      grp;
  logic [bse_pkg::GroupW-1:0]      masked;
  logic [bse_pkg::GrpBits-1:0]     hit_k;
  logic [bse_pkg::IdxW-1:0]        hit_sym;
  logic                            in_scope;
  logic                            hit_ok;
  logic [bse_pkg::PosW:0]          next_base;

  // command decode on the incoming byte
  assign in_range = ({1'b0, symbol} < (bse_pkg::SymW + 1)'(bse_pkg::SymbolCount));
  assign member   = in_range && member_map[symbol[bse_pkg::IdxW-1:0]];
  assign emit     = (func == bse_pkg::FuncPass)
                 || (func == bse_pkg::FuncAbsent && !member)
                 || (func == bse_pkg::FuncPresent && member);

  // one group of the set per scan step
  assign map_pad  = bse_pkg::PadW'(member_map);
  assign gidx     = pos[bse_pkg::GrpBits +: bse_pkg::GidxW];
  assign grp      = map_pad[int'(gidx) * bse_pkg::GroupW +: bse_pkg::GroupW];
  assign masked   = grp & ({bse_pkg::GroupW{1'b1}} << pos[bse_pkg::GrpBits-1:0]);
  assign in_scope = (pos < bse_pkg::PosW'(bse_pkg::SymbolCount));
  assign hit_ok   = in_scope && (|masked);

  always_comb begin
    hit_k = '0;
    for (int k = bse_pkg::GroupW - 1; k >= 0; k--) begin
      if (masked[k]) begin
        hit_k = bse_pkg::GrpBits'(k);
      end
    end
  end

  assign hit_sym   = bse_pkg::IdxW'({gidx, hit_k});
  assign next_base = (((bse_pkg::PosW + 1)'(pos) >> bse_pkg::GrpBits) + 1'b1)
                     << bse_pkg::GrpBits;

  assign status.hit       = hit_ok;
  assign status.exhausted = !hit_ok && (!in_scope
                            || next_base >= (bse_pkg::PosW + 1)'(bse_pkg::SymbolCount));
  assign status.fin       = fin_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      member_map   <= '0;
      drain_cursor <= '0;
    end else if (cmd.accept) begin
      case (func)
        bse_pkg::FuncClear: begin
          member_map   <= '0;
          drain_cursor <= '0;
        end
        bse_pkg::FuncMark, bse_pkg::FuncPass: begin
          if (in_range) begin
            member_map[symbol[bse_pkg::IdxW-1:0]] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.take) begin
      drain_cursor <= bse_pkg::PosW'(hit_sym) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos   <= drain_cursor;
      fin_q <= final_req;
    end else if (cmd.take) begin
      pos   <= bse_pkg::PosW'(hit_sym) + 1'b1;
      found <= hit_sym;
    end else if (cmd.advance) begin
      pos   <= next_base[bse_pkg::PosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else if (cmd.accept) begin
      strobe <= (func != bse_pkg::FuncDrain) && (emit || final_req);
    end else begin
      strobe <= cmd.emit_hit || cmd.emit_found || cmd.emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_symbol <= emit ? symbol : '0;
      present    <= emit;
      last       <= final_req;
    end else if (cmd.emit_hit) begin
      out_symbol <= bse_pkg::SymW'(hit_sym);
      present    <= 1'b1;
      last       <= 1'b1;
    end else if (cmd.emit_found) begin
      out_symbol <= bse_pkg::SymW'(found);
      present    <= 1'b1;
      last       <= cmd.found_last || fin_q;
    end else if (cmd.emit_end) begin
      out_symbol <= '0;
      present    <= 1'b0;
      last       <= 1'b1;
    end
  end

  a_bare_marker_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !present |-> last)
    else $error("bare end marker without last");

  a_cursor_bounded: assert property (@(posedge clk) disable iff (rst)
    drain_cursor <= bse_pkg::PosW'(bse_pkg::SymbolCount))
    else $error("drain cursor beyond the set");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && func == bse_pkg::FuncClear |=> member_map == '0 && drain_cursor == '0)
    else $error("clear left members or cursor behind");

endmodule

@@ test/tb_byte_set_engine.sv @@
module tb_byte_set_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // run sizing: drain holds busy while it scans and every request may wait through
  // a random idle gap, yet even a drain-only run stays far below the cycle limit
  localparam int RequestTarget = 1650;
  localparam int CycleLimit    = 500000;
  localparam int DrainSettle   = 40;
  localparam int ShownFaults   = 10;
  localparam int ClkPeriod     = 10;

  // codes the block does not decode; they only obey the end marker rule
  localparam logic [2:0] FuncSpare6 = 3'd6;
  localparam logic [2:0] FuncSpare7 = 3'd7;

  typedef struct {
    logic [2:0]               func;
    logic [bse_pkg::SymW-1:0] symbol;
    logic                     fin;
    int                       gap;
  } request_t;

  typedef struct {
    logic [bse_pkg::SymW-1:0] symbol;
    logic                     present;
    logic                     last;
  } byte_out_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     start     = 1'b0;
  logic [2:0]               func      = bse_pkg::FuncClear;
  logic [bse_pkg::SymW-1:0] symbol    = '0;
  logic                     final_req = 1'b0;
  logic                     busy;
  logic                     strobe;
  logic [bse_pkg::SymW-1:0] out_symbol;
  logic                     present;
  logic                     last;

  // requests waiting to be driven, and results owed by the block in order
  request_t  queued[$];
  byte_out_t due[$];

  // shadow of the block's state, advanced as each request is accepted
  logic [bse_pkg::SymbolCount-1:0] members = '0;
  logic [8:0]                      cursor  = '0;

  bit holding    = 1'b0;
  int idle_count = 0;
  int faults     = 0;
  int cycles     = 0;

  // shape of the random stimulus, set per sequence
  bit bursty      = 1'b0;
  bit narrow      = 1'b0;
  int window_base = 0;

  byte_set_engine dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .symbol    (symbol),
    .final_req (final_req),
    .strobe    (strobe),
    .out_symbol(out_symbol),
    .present   (present),
    .last      (last)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // smallest member at or above from, -1 when the rest of the set is empty
  function automatic int next_member(input int from);
    int v;
    for (v = from; v < bse_pkg::SymbolCount && v < 256; v++) begin
      if (members[v]) return v;
    end
    return -1;
  endfunction

  // advance the shadow set by one accepted request and queue what it owes
  function automatic void predict_set_op(input logic [2:0] f,
                                         input logic [bse_pkg::SymW-1:0] s,
                                         input logic fin);
    byte_out_t r;
    bit        emit;
    bit        owed;
    int        m;
    emit = 1'b0;
    owed = 1'b0;
    r    = '{symbol: '0, present: 1'b0, last: 1'b1};
    case (f)
      bse_pkg::FuncClear: begin
        members = '0;
        cursor  = '0;
      end
      bse_pkg::FuncMark: begin
        if (int'(s) < bse_pkg::SymbolCount) members[s] = 1'b1;
      end
      bse_pkg::FuncPass: begin
        if (int'(s) < bse_pkg::SymbolCount) members[s] = 1'b1;
        emit = 1'b1;
      end
      bse_pkg::FuncAbsent: begin
        emit = !(int'(s) < bse_pkg::SymbolCount && members[s]);
      end
      bse_pkg::FuncPresent: begin
        emit = int'(s) < bse_pkg::SymbolCount && members[s];
      end
      bse_pkg::FuncDrain: begin
        // drain always answers: the next member, or a bare end marker
        owed = 1'b1;
        m = next_member(int'(cursor));
        if (m >= 0) begin
          cursor    = 9'(m + 1);
          r.symbol  = m[bse_pkg::SymW-1:0];
          r.present = 1'b1;
          r.last    = fin || next_member(m + 1) < 0;
        end
      end
      default: ;
    endcase
    if (emit) begin
      owed      = 1'b1;
      r.symbol  = s;
      r.present = 1'b1;
      r.last    = fin;
    end else if (fin) begin
      owed = 1'b1;
    end
    if (owed) due.push_back(r);
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= ShownFaults) $display("%0t: %s", $time, msg);
  endfunction

  // driver: a request is taken at an edge where start is high and busy low
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic     drive_start;
    if (rst) begin
      start      <= 1'b0;
      holding    = 1'b0;
      idle_count = 0;
    end else begin
      drive_start = start;
      if (start && !busy) begin
        predict_set_op(func, symbol, final_req);
        holding     = 1'b0;
        drive_start = 1'b0;
      end
      // present the next request once its idle gap has passed; a zero gap keeps
      // start high straight through, so start gets a single assignment per edge
      if (!holding && queued.size() != 0) begin
        if (idle_count < queued[0].gap) begin
          idle_count++;
        end else begin
          nxt         = queued.pop_front();
          func        <= nxt.func;
          symbol      <= nxt.symbol;
          final_req   <= nxt.fin;
          drive_start = 1'b1;
          holding     = 1'b1;
          idle_count  = 0;
        end
      end
      start <= drive_start;
    end
  end

  // monitor: each strobe is one result, checked against the oldest owed one
  always @(posedge clk) begin : check_results
    byte_out_t want;
    if (!rst && strobe === 1'b1) begin
      if (due.size() == 0) begin
        note_fault($sformatf("unexpected result: symbol %0d present %0b last %0b",
                             out_symbol, present, last));
      end else begin
        want = due.pop_front();
        if (out_symbol !== want.symbol || present !== want.present || last !== want.last)
          note_fault($sformatf({"result mismatch: expected symbol %0d present %0b last %0b,",
                                " got symbol %0d present %0b last %0b"},
                               want.symbol, want.present, want.last,
                               out_symbol, present, last));
      end
    end
  end

  task automatic push_req(input logic [2:0] f, input int s, input logic fin);
    request_t r;
    r.func   = f;
    r.symbol = s[bse_pkg::SymW-1:0];
    r.fin    = fin;
    r.gap    = bursty ? 0 : $urandom_range(0, 5);
    queued.push_back(r);
  endtask

  // byte values: a narrow window gives plenty of hits between operands
  function automatic int pick_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 255 : 0;
    if (narrow) return window_base + $urandom_range(0, 15);
    return $urandom_range(0, 255);
  endfunction

  // one operand of n bytes; the last one closes the result run with a chance of end_pct percent
  task automatic stream_operand(input logic [2:0] f, input int n, input int end_pct);
    int i;
    for (i = 0; i < n; i++)
      push_req(f, pick_byte(), i == n - 1 && $urandom_range(0, 99) < end_pct);
  endtask

  // one random set operation starting from an empty set, or plain noise
  task automatic random_set_op();
    int kind;
    int na;
    int nb;
    int i;
    kind        = $urandom_range(0, 9);
    na          = $urandom_range(1, 12);
    nb          = $urandom_range(1, 12);
    bursty      = $urandom_range(0, 2) == 0;
    narrow      = $urandom_range(0, 1);
    window_base = $urandom_range(0, 240);
    push_req(bse_pkg::FuncClear, $urandom_range(0, 255), $urandom_range(0, 7) == 0);
    case (kind)
      0, 1: begin
        // union: a passes and marks, then b only where absent
        stream_operand(bse_pkg::FuncPass, na, 90);
        stream_operand(bse_pkg::FuncAbsent, nb, 90);
      end
      2, 3: begin
        // difference: mark b, then a only where absent
        stream_operand(bse_pkg::FuncMark, nb, 10);
        stream_operand(bse_pkg::FuncAbsent, na, 90);
      end
      4, 5: begin
        // intersection: mark b, then a only where present
        stream_operand(bse_pkg::FuncMark, nb, 10);
        stream_operand(bse_pkg::FuncPresent, na, 90);
      end
      6, 7: begin
        // sorted listing, run past the end; random marks mid-listing, some behind the cursor
        stream_operand(bse_pkg::FuncMark, na, 10);
        for (i = 0; i < na + 2; i++) begin
          if ($urandom_range(0, 7) == 0) push_req(bse_pkg::FuncMark, pick_byte(), 1'b0);
          push_req(bse_pkg::FuncDrain, $urandom_range(0, 255), $urandom_range(0, 9) == 0);
        end
      end
      default: begin
        for (i = 0; i < na; i++)
          push_req(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 1));
      end
    endcase
  endtask

  initial begin : run_test
    // directed requests: extremes, every command, end markers, spare codes
    bursty = 1'b0;
    push_req(bse_pkg::FuncClear,   0,   1'b0);
    push_req(bse_pkg::FuncMark,    0,   1'b0);
    push_req(bse_pkg::FuncMark,    255, 1'b0);
    push_req(bse_pkg::FuncPass,    0,   1'b0);
    push_req(bse_pkg::FuncPass,    255, 1'b1);
    push_req(bse_pkg::FuncAbsent,  0,   1'b0);   // member, nothing owed
    push_req(bse_pkg::FuncAbsent,  128, 1'b1);
    push_req(bse_pkg::FuncPresent, 255, 1'b0);
    push_req(bse_pkg::FuncPresent, 7,   1'b1);   // not a member, bare end marker
    push_req(bse_pkg::FuncDrain,   255, 1'b0);
    push_req(bse_pkg::FuncDrain,   0,   1'b0);
    push_req(bse_pkg::FuncDrain,   0,   1'b0);   // listing exhausted
    push_req(FuncSpare6,           85,  1'b0);
    push_req(FuncSpare7,           170, 1'b1);
    push_req(bse_pkg::FuncClear,   255, 1'b1);
    push_req(bse_pkg::FuncMark,    170, 1'b1);
    push_req(bse_pkg::FuncMark,    85,  1'b0);
    push_req(bse_pkg::FuncDrain,   0,   1'b1);   // final forces last with members left
    push_req(bse_pkg::FuncDrain,   0,   1'b0);
    push_req(bse_pkg::FuncDrain,   0,   1'b0);
    push_req(bse_pkg::FuncClear,   0,   1'b0);
    push_req(bse_pkg::FuncDrain,   0,   1'b0);   // empty set
    push_req(bse_pkg::FuncPass,    0,   1'b0);
    push_req(bse_pkg::FuncPass,    0,   1'b1);   // duplicate kept
    push_req(bse_pkg::FuncAbsent,  0,   1'b1);
    while (queued.size() < RequestTarget) random_set_op();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while ((queued.size() != 0 || holding || due.size() != 0) && cycles < CycleLimit)
      @(posedge clk);
    if (cycles >= CycleLimit) begin
      $display("byte_set_engine verification failed");
    end else begin
      // catch stray strobes from a late drain scan
      repeat (DrainSettle) @(posedge clk);
      if (faults == 0) begin
        $display("byte_set_engine verification clean");
      end else begin
        $display("byte_set_engine verification failed");
      end
    end
    $finish;
  end

endmodule
